>>> rtl/spd_pkg.sv
package spd_pkg;

   // Framing bytes
   localparam logic [7:0] START_BYTE  = 8'h21;   // '!'
   localparam logic [7:0] TYPE_ACCEL  = 8'h41;   // 'A'
   localparam logic [7:0] TYPE_GYRO   = 8'h47;   // 'G'
   localparam logic [7:0] TYPE_MAG    = 8'h4D;   // 'M'
   localparam logic [7:0] TYPE_QUAT   = 8'h51;   // 'Q'
   localparam logic [7:0] TYPE_BUTTON = 8'h42;   // 'B'
   localparam logic [7:0] TYPE_COLOR  = 8'h43;   // 'C'
   localparam logic [7:0] TYPE_LOC    = 8'h4C;   // 'L'
   localparam logic [7:0] ASCII_ZERO  = 8'h30;   // '0'
   localparam logic [7:0] ASCII_ONE   = 8'h31;   // '1'

   // Full frame lengths counted from the start byte
   localparam logic [4:0] LEN_VECTOR  = 5'd15;
   localparam logic [4:0] LEN_QUAT    = 5'd19;
   localparam logic [4:0] LEN_BUTTON  = 5'd5;
   localparam logic [4:0] LEN_COLOR   = 5'd6;

   localparam logic [4:0] COUNT_MAX   = 5'd31;
   localparam logic [4:0] COUNT_TYPE  = 5'd2;
   localparam logic [4:0] COUNT_PAY0  = 5'd3;

   // Packet kinds
   localparam logic [2:0] KIND_ACCEL  = 3'd0;
   localparam logic [2:0] KIND_GYRO   = 3'd1;
   localparam logic [2:0] KIND_MAG    = 3'd2;
   localparam logic [2:0] KIND_QUAT   = 3'd3;
   localparam logic [2:0] KIND_BUTTON = 3'd4;
   localparam logic [2:0] KIND_COLOR  = 3'd5;
   localparam logic [2:0] KIND_LOC    = 3'd6;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   localparam int PAY_BYTES = 16;   // largest payload (quaternion)

   typedef struct packed {
      logic       known;
      logic [4:0] len;
      logic [2:0] kind;
   } frame_info_type;

   // Completed packet handed from the parser to the result stage
   typedef struct packed {
      logic             done;
      logic [2:0]       kind;
      logic             status;
      logic [1:0]       last_idx;
      logic [3:0][31:0] words;
   } pkt_type;

   function automatic frame_info_type frame_info(input logic [7:0] t);
      frame_info_type fi;
      fi = '{known: 1'b1, len: LEN_VECTOR, kind: KIND_ACCEL};
      case (t)
         TYPE_ACCEL:  fi.kind = KIND_ACCEL;
         TYPE_GYRO:   fi.kind = KIND_GYRO;
         TYPE_MAG:    fi.kind = KIND_MAG;
         TYPE_LOC:    fi.kind = KIND_LOC;
         TYPE_QUAT: begin
            fi.kind = KIND_QUAT;
            fi.len  = LEN_QUAT;
         end
         TYPE_BUTTON: begin
            fi.kind = KIND_BUTTON;
            fi.len  = LEN_BUTTON;
         end
         TYPE_COLOR: begin
            fi.kind = KIND_COLOR;
            fi.len  = LEN_COLOR;
         end
         default: begin
            fi = '{known: 1'b0, len: 5'd0, kind: KIND_ACCEL};
         end
      endcase
      return fi;
   endfunction

endpackage

>>> rtl/spd_if.sv
interface spd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface spd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  packet_kind;
   logic [1:0]  word_index;
   logic [31:0] payload_word;
   logic        status;
   logic        last_word;

   modport source (output valid, output packet_kind, output word_index,
                   output payload_word, output status, output last_word,
                   input ready);
   modport sink   (input valid, input packet_kind, input word_index,
                   input payload_word, input status, input last_word,
                   output ready);
endinterface

>>> rtl/spd_parser.sv
module spd_parser
   import spd_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 19
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_take,
   input  logic [7:0] in_byte,
   output logic       near_end,
   output pkt_type    pkt
);

   localparam int STORE_DEPTH = MAX_FRAME_BYTES - 3;
   localparam int IDX_W       = $clog2(STORE_DEPTH);

   logic       frame_active_ff, frame_active_in;
   logic [4:0] byte_count_ff, byte_count_in;
   logic [7:0] type_code_ff, type_code_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] store_ff [STORE_DEPTH];

   logic           [4:0] cnt_inc;
   logic           [4:0] wr_pos;
   logic                 wr_en;
   logic                 pkt_done;
   logic           [7:0] type_eff;
   frame_info_type       fi;
   frame_info_type       fi_held;
   logic           [7:0] pay [PAY_BYTES];

   assign cnt_inc  = (byte_count_ff == COUNT_MAX) ? COUNT_MAX : byte_count_ff + 5'd1;
   assign type_eff = (cnt_inc == COUNT_TYPE) ? in_byte : type_code_ff;
   assign fi       = frame_info(type_eff);
   assign fi_held  = frame_info(type_code_ff);
   assign wr_pos   = cnt_inc - COUNT_PAY0;

   // Next byte would close the frame (type already known, so count >= 2)
   assign near_end = frame_active_ff && fi_held.known && (cnt_inc == fi_held.len);

   always_comb begin
      frame_active_in = frame_active_ff;
      byte_count_in   = byte_count_ff;
      type_code_in    = type_code_ff;
      running_sum_in  = running_sum_ff;
      wr_en           = 1'b0;
      pkt_done        = 1'b0;
      if (byte_take) begin
         if (in_byte == START_BYTE) begin
            frame_active_in = 1'b1;
            byte_count_in   = 5'd1;
            type_code_in    = 8'd0;
            running_sum_in  = START_BYTE;
         end else if (frame_active_ff) begin
            byte_count_in = cnt_inc;
            type_code_in  = type_eff;
            if (!fi.known) begin
               frame_active_in = 1'b0;
            end else if (cnt_inc < fi.len) begin
               wr_en          = (cnt_inc >= COUNT_PAY0) && (wr_pos < 5'(STORE_DEPTH));
               running_sum_in = running_sum_ff + in_byte;
            end else begin
               frame_active_in = 1'b0;
               pkt_done        = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff <= 1'b0;
         byte_count_ff   <= 5'd0;
         type_code_ff    <= 8'd0;
         running_sum_ff  <= 8'd0;
      end else begin
         frame_active_ff <= frame_active_in;
         byte_count_ff   <= byte_count_in;
         type_code_ff    <= type_code_in;
         running_sum_ff  <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_pos[IDX_W-1:0]] <= in_byte;
      end
   end

   for (genvar g = 0; g < PAY_BYTES; g++) begin : g_pay
      assign pay[g] = store_ff[g];
   end

   // Packet contents, valid only alongside pkt.done
   always_comb begin
      pkt.done     = pkt_done;
      pkt.kind     = fi.kind;
      pkt.status   = STATUS_OK;
      pkt.last_idx = 2'd2;
      for (int w = 0; w < 4; w++) begin
         pkt.words[w] = {pay[4*w+3], pay[4*w+2], pay[4*w+1], pay[4*w]};
      end
      if (~running_sum_ff != in_byte) begin
         pkt.status   = STATUS_BAD;
         pkt.last_idx = 2'd0;
         pkt.words[0] = 32'd0;
      end else if (fi.kind == KIND_BUTTON) begin
         pkt.last_idx = 2'd0;
         pkt.words[0] = {23'd0, pay[1] == ASCII_ONE, pay[0] - ASCII_ZERO};
      end else if (fi.kind == KIND_COLOR) begin
         pkt.last_idx = 2'd0;
         pkt.words[0] = {8'd0, pay[2], pay[1], pay[0]};
      end else if (fi.kind == KIND_QUAT) begin
         pkt.last_idx = 2'd3;
      end
   end

endmodule

>>> rtl/spd_emitter.sv
module spd_emitter
   import spd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  pkt_type   pkt,
   output logic      busy,
   spd_rsp_if.source rsp
);

   logic             valid_ff, valid_in;
   logic [1:0]       idx_ff, idx_in;
   logic [2:0]       kind_ff;
   logic             status_ff;
   logic [1:0]       last_idx_ff;
   logic [3:0][31:0] words_ff;
   logic             is_last;

   assign is_last = (idx_ff == last_idx_ff);
   assign busy    = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (valid_ff && rsp.ready) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      // parser only closes a frame while this stage is empty
      if (pkt.done) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pkt.done) begin
         kind_ff     <= pkt.kind;
         status_ff   <= pkt.status;
         last_idx_ff <= pkt.last_idx;
         words_ff    <= pkt.words;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.packet_kind  = kind_ff;
   assign rsp.word_index   = idx_ff;
   assign rsp.payload_word = words_ff[idx_ff];
   assign rsp.status       = status_ff;
   assign rsp.last_word    = is_last;

endmodule

>>> rtl/sensor_packet_deframer_core.sv
// Byte-serial deframer for '!'-framed sensor packets. One received byte is
// taken per req beat; a '!' always opens a new frame, the next byte picks
// the type (A, G, M, L: 12 payload bytes, Q: 16, B: 2, C: 3) and a checksum
// byte closes it. When the checksum (inverted 8-bit sum of every earlier
// frame byte) matches, the payload leaves on rsp as little-endian 32-bit
// beats, one per cycle while rsp is ready, last_word marking the final one;
// a mismatch gives a single beat with status set. Unknown types and bytes
// after a closed frame are dropped silently until the next '!'. Rate: one
// byte per cycle while req is ready; the parser updates on each taken byte
// and a finished packet moves to the result buffer (first rsp beat in the
// cycle after the checksum byte), so req stays ready while rsp beats drain.
// req_chan.ready drops only on the byte closing a frame while the previous
// packet (at most four beats) still waits in the result buffer; frames are
// at least five bytes, so with rsp taken every cycle this never happens.
module sensor_packet_deframer_core
   import spd_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 19   // sets payload store depth (minus 3)
) (
   input  logic      clock,
   input  logic      reset,
   spd_req_if.sink   req_chan,
   spd_rsp_if.source rsp_chan
);

   logic    near_end;
   logic    busy;
   logic    byte_take;
   pkt_type pkt;

   // hold off only a frame-closing beat while the buffer is occupied
   assign req_chan.ready = !(near_end && busy);
   assign byte_take      = req_chan.valid && req_chan.ready;

   spd_parser #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .in_byte   (req_chan.in_byte),
      .near_end  (near_end),
      .pkt       (pkt)
   );

   spd_emitter u_emitter (
      .clock (clock),
      .reset (reset),
      .pkt   (pkt),
      .busy  (busy),
      .rsp   (rsp_chan)
   );

endmodule

>>> rtl/spd_checker.sv
module spd_checker
   import spd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [1:0]  rsp_index,
   input logic [31:0] rsp_word,
   input logic        rsp_status,
   input logic        rsp_last
);

   // result beat held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index) && $stable(rsp_kind))
      else $error("rsp beat dropped while stalled");

   // a packet's beats follow without gaps, index counting up
   a_rsp_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_index == $past(rsp_index) + 2'd1 && $stable(rsp_kind))
      else $error("packet beats out of sequence");

   // checksum error is a lone zero beat
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD |->
         rsp_last && rsp_index == 2'd0 && rsp_word == 32'd0)
      else $error("malformed error beat");

   // button and colour packets are one beat
   a_short_pkt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_BUTTON || rsp_kind == KIND_COLOR) |->
         rsp_last && rsp_index == 2'd0)
      else $error("short packet spans more than one beat");

endmodule

bind sensor_packet_deframer_core spd_checker u_spd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_kind   (rsp_chan.packet_kind),
   .rsp_index  (rsp_chan.word_index),
   .rsp_word   (rsp_chan.payload_word),
   .rsp_status (rsp_chan.status),
   .rsp_last   (rsp_chan.last_word)
);

>>> tb/sensor_packet_deframer_core_tb.sv
`timescale 1ns / 1ps

module sensor_packet_deframer_core_tb;
   import spd_pkg::*;

   localparam int RANDOM_BYTES = 305;     // framed bytes in the random part
   localparam int LONG_HOLD    = 120;     // receiver hold-off for the pressure phase
   localparam int TAIL_CYCLES  = 20;      // quiet time after the last beat
   localparam int CYCLE_LIMIT  = 300000;

   localparam logic [7:0] FRAME_TYPES [7] = '{TYPE_ACCEL, TYPE_GYRO, TYPE_MAG, TYPE_QUAT,
                                              TYPE_BUTTON, TYPE_COLOR, TYPE_LOC};

   // One rsp beat as the block should present it
   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  idx;
      logic [31:0] word;
      logic        status;
      logic        last;
   } rsp_beat_type;

   // Tracks the deframer state byte by byte and holds the beats it owes us
   class deframe_scoreboard;
      bit            in_frame;
      logic [4:0]    frame_count;
      logic [7:0]    frame_type;
      logic [7:0]    frame_sum;
      logic [7:0]    body [16];
      rsp_beat_type  owed_beats [$];
      int            errors, beats_seen, bytes_seen, good_pkts, bad_pkts;

      function new();
         in_frame    = 1'b0;
         frame_count = '0;
         frame_type  = '0;
         frame_sum   = '0;
         foreach (body[i]) body[i] = '0;
      endfunction

      function int pending();
         return owed_beats.size();
      endfunction

      function void owe(logic [2:0] kind, logic [1:0] idx, logic [31:0] word,
                        logic status, logic last);
         rsp_beat_type b;
         b = '{kind: kind, idx: idx, word: word, status: status, last: last};
         owed_beats.push_back(b);
      endfunction

      // Type byte to packet kind and full frame length; known = 0 for anything else
      function void decode(input logic [7:0] t, output bit known,
                           output logic [2:0] kind, output logic [4:0] len);
         known = 1'b1;
         kind  = KIND_ACCEL;
         len   = LEN_VECTOR;
         case (t)
            TYPE_ACCEL:  kind = KIND_ACCEL;
            TYPE_GYRO:   kind = KIND_GYRO;
            TYPE_MAG:    kind = KIND_MAG;
            TYPE_LOC:    kind = KIND_LOC;
            TYPE_QUAT: begin
               kind = KIND_QUAT;
               len  = LEN_QUAT;
            end
            TYPE_BUTTON: begin
               kind = KIND_BUTTON;
               len  = LEN_BUTTON;
            end
            TYPE_COLOR: begin
               kind = KIND_COLOR;
               len  = LEN_COLOR;
            end
            default: begin
               known = 1'b0;
               len   = '0;
            end
         endcase
      endfunction

      // Called for every accepted req beat
      function void note_byte(logic [7:0] b);
         bit          known;
         logic [2:0]  kind;
         logic [4:0]  len;
         logic [7:0]  button;
         int          nwords;
         bytes_seen++;
         // '!' always reopens, whatever was in flight
         if (b == START_BYTE) begin
            in_frame    = 1'b1;
            frame_count = 5'd1;
            frame_type  = '0;
            frame_sum   = b;
            return;
         end
         if (!in_frame) return;
         if (frame_count < COUNT_MAX) frame_count++;
         if (frame_count == COUNT_TYPE) frame_type = b;
         decode(frame_type, known, kind, len);
         if (!known) begin
            in_frame = 1'b0;
            return;
         end
         if (frame_count < len) begin
            if (frame_count >= COUNT_PAY0 && int'(frame_count) - 3 < 16)
               body[frame_count - COUNT_PAY0] = b;
            frame_sum = frame_sum + b;
            return;
         end
         // checksum byte
         in_frame = 1'b0;
         if (~frame_sum != b) begin
            bad_pkts++;
            owe(kind, 2'd0, 32'd0, STATUS_BAD, 1'b1);
            return;
         end
         good_pkts++;
         if (kind == KIND_BUTTON) begin
            button = body[0] - ASCII_ZERO;
            owe(kind, 2'd0, {23'd0, body[1] == ASCII_ONE, button}, STATUS_OK, 1'b1);
         end else if (kind == KIND_COLOR) begin
            owe(kind, 2'd0, {8'd0, body[2], body[1], body[0]}, STATUS_OK, 1'b1);
         end else begin
            nwords = (kind == KIND_QUAT) ? 4 : 3;
            for (int i = 0; i < nwords; i++)
               owe(kind, 2'(i), {body[4*i+3], body[4*i+2], body[4*i+1], body[4*i]},
                   STATUS_OK, i == nwords - 1);
         end
      endfunction

      function void report(string field, logic [31:0] exp, logic [31:0] act);
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp, act);
      endfunction

      // Called for every accepted rsp beat
      function void check_beat(rsp_beat_type got);
         rsp_beat_type exp;
         beats_seen++;
         if (owed_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected rsp beat, expected none, got kind %0d idx %0d",
                     $time, got.kind, got.idx);
            $display("   word %0h status %0d last %0d", got.word, got.status, got.last);
            return;
         end
         exp = owed_beats.pop_front();
         if (got.kind !== exp.kind)
            report("packet_kind", 32'(exp.kind), 32'(got.kind));
         if (got.idx !== exp.idx)
            report("word_index", 32'(exp.idx), 32'(got.idx));
         if (got.word !== exp.word)
            report("payload_word", exp.word, got.word);
         if (got.status !== exp.status)
            report("status", 32'(exp.status), 32'(got.status));
         if (got.last !== exp.last)
            report("last_word", 32'(exp.last), 32'(got.last));
      endfunction
   endclass

   logic clock;
   logic reset;

   spd_req_if req_chan ();
   spd_rsp_if rsp_chan ();

   sensor_packet_deframer_core #(.MAX_FRAME_BYTES(19)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deframe_scoreboard sb = new();

   logic [7:0] tx_bytes [$];   // bytes queued for the next burst on req
   bit         req_gaps_on;
   bit         rsp_stalls_on;
   bit         long_hold;      // set by the stimulus, cleared by the receiver
   int         cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Watchdog: a hung handshake ends the run here
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d beats still owed", cycle_count, sb.pending());
      $display("Test completed with failures");
      $finish;
   end

   // Mostly short idles, now and then a longer one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   // Any byte but '!', so a frame body does not restart itself
   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == START_BYTE) b = 8'hA1;
      return b;
   endfunction

   function automatic int pay_len(logic [7:0] t);
      case (t)
         TYPE_QUAT:   return 16;
         TYPE_BUTTON: return 2;
         TYPE_COLOR:  return 3;
         default:     return 12;
      endcase
   endfunction

   // Queue a complete frame; corrupt flips some checksum bits
   function automatic void add_frame(logic [7:0] t, logic [7:0] pay [$], bit corrupt);
      logic [7:0] sum;
      logic [7:0] check;
      sum = START_BYTE + t;
      foreach (pay[i]) sum = sum + pay[i];
      check = ~sum;
      if (corrupt) check = check ^ 8'($urandom_range(1, 255));
      tx_bytes.push_back(START_BYTE);
      tx_bytes.push_back(t);
      foreach (pay[i]) tx_bytes.push_back(pay[i]);
      tx_bytes.push_back(check);
   endfunction

   // Random frame of a random known type, button bytes biased towards digits
   function automatic void add_random_frame(bit corrupt);
      logic [7:0] t;
      logic [7:0] pay [$];
      int         r;
      t = FRAME_TYPES[$urandom_range(0, 6)];
      if (t == TYPE_BUTTON) begin
         pay.push_back(($urandom_range(0, 3) == 0) ? body_byte()
                                                  : ASCII_ZERO + 8'($urandom_range(0, 9)));
         r = $urandom_range(0, 4);
         pay.push_back(r < 2 ? ASCII_ONE : (r < 4 ? ASCII_ZERO : body_byte()));
      end else begin
         for (int i = 0; i < pay_len(t); i++) pay.push_back(body_byte());
      end
      add_frame(t, pay, corrupt);
   endfunction

   // Offer one byte and hold it until taken; returns at the following falling edge.
   // valid is left high so back-to-back bytes go out without a bubble.
   task automatic send_byte(logic [7:0] b);
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_byte(b);
      @(negedge clock);
   endtask

   task automatic send_tx();
      logic [7:0] b;
      while (tx_bytes.size() != 0) begin
         b = tx_bytes.pop_front();
         send_byte(b);
         if (req_gaps_on && $urandom_range(0, 99) < 30) begin
            req_chan.valid   <= 1'b0;
            req_chan.in_byte <= 8'($urandom_range(0, 255));
            repeat (idle_len()) @(negedge clock);
         end
      end
   endtask

   // Stop offering and let every owed beat come home, plus the output latency
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // rsp side: random stalls, or one long hold-off on request
   initial begin
      int stall_left;
      int held;
      stall_left     = 0;
      held           = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            held++;
            if (held >= LONG_HOLD) begin
               held      = 0;
               long_hold = 1'b0;
            end
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 30) begin
            rsp_chan.ready <= 1'b0;
            stall_left = idle_len() - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Checks every accepted rsp beat against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_beat('{kind: rsp_chan.packet_kind, idx: rsp_chan.word_index,
                         word: rsp_chan.payload_word, status: rsp_chan.status,
                         last: rsp_chan.last_word});
   end

   initial begin
      int framed;
      int frames;
      int r;
      int k;
      logic [7:0] t;
      logic [7:0] pay [$];

      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h00;
      reset            = 1'b1;
      req_gaps_on      = 1'b1;
      rsp_stalls_on    = 1'b1;
      long_hold        = 1'b0;
      framed           = 0;
      frames           = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part ---
      // noise ahead of any '!': all zeros and all ones, both ignored
      tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'hFF);
      // button byte below '0' wraps, state '1' sets the pressed bit
      pay = '{8'h00, ASCII_ONE};
      add_frame(TYPE_BUTTON, pay, 1'b0);
      // colour with extreme channel values
      pay = '{8'hFF, 8'h00, 8'h80};
      add_frame(TYPE_COLOR, pay, 1'b0);
      // unknown type drops the frame
      tx_bytes.push_back(START_BYTE);
      tx_bytes.push_back(8'h5A);
      // '!' in the middle of a frame restarts it; the new frame has a bad checksum
      tx_bytes.push_back(START_BYTE);
      tx_bytes.push_back(TYPE_COLOR);
      tx_bytes.push_back(8'h35);
      pay = '{8'h39, ASCII_ZERO};
      add_frame(TYPE_BUTTON, pay, 1'b1);
      // run-on bytes after a finished frame are ignored
      tx_bytes.push_back(8'h55);
      tx_bytes.push_back(8'hAA);
      send_tx();
      wait_drained();

      // --- random part ---
      while (framed < RANDOM_BYTES) begin
         // new idling mix every dozen frames; sometimes none at all
         if (frames % 12 == 0) begin
            req_gaps_on   = $urandom_range(0, 3) != 0;
            rsp_stalls_on = $urandom_range(0, 3) != 0;
         end

         if (frames == 18) begin
            // receiver goes quiet while frames keep coming back to back,
            // so the result buffer fills and req has to back off
            req_gaps_on = 1'b0;
            long_hold   = 1'b1;
            repeat (8) add_random_frame(1'b0);
         end else if (frames == 30) begin
            // sender waits for the pipe to empty before carrying on
            wait_drained();
            add_random_frame(1'b0);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               add_random_frame(1'b0);
            end else if (r < 80) begin
               add_random_frame(1'b1);
            end else if (r < 86) begin
               // cut short: the next '!' takes over
               t = FRAME_TYPES[$urandom_range(0, 6)];
               tx_bytes.push_back(START_BYTE);
               tx_bytes.push_back(t);
               k = $urandom_range(0, pay_len(t));
               repeat (k) tx_bytes.push_back(body_byte());
            end else if (r < 91) begin
               // unknown type then some junk
               do begin
                  t = body_byte();
                  k = 0;
                  foreach (FRAME_TYPES[i]) if (FRAME_TYPES[i] == t) k = 1;
               end while (k != 0);
               tx_bytes.push_back(START_BYTE);
               tx_bytes.push_back(t);
               repeat ($urandom_range(0, 4)) tx_bytes.push_back(body_byte());
            end else if (r < 96) begin
               // frame that runs on past its length
               add_random_frame(1'b0);
               repeat ($urandom_range(2, 5)) tx_bytes.push_back(body_byte());
            end else begin
               // line noise between frames, not counted towards the total
               repeat ($urandom_range(1, 4)) tx_bytes.push_back(body_byte());
               framed -= tx_bytes.size();
            end
         end
         framed += tx_bytes.size();
         frames++;
         send_tx();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d bytes over %0d random bursts: %0d good packets, %0d checksum errors,",
               sb.bytes_seen, frames, sb.good_pkts, sb.bad_pkts);
      $display("%0d rsp beats checked, including a long receiver hold-off and a full drain",
               sb.beats_seen);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> filelist.f
rtl/spd_pkg.sv
rtl/spd_if.sv
rtl/spd_parser.sv
rtl/spd_emitter.sv
rtl/sensor_packet_deframer_core.sv
rtl/spd_checker.sv
tb/sensor_packet_deframer_core_tb.sv
